@@ sv/qim_pkg.sv @@
// ----------------------------------------------------------------------------
// qim_pkg
// shared types, codes and saturating arithmetic of the queue interval monitor
// ----------------------------------------------------------------------------
package qim_pkg;

    localparam logic [1:0] ACT_ENQ   = 2'd0;
    localparam logic [1:0] ACT_DEQ   = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;
    localparam logic [1:0] ACT_OTHER = 2'd3;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_FILT_ON  = 2'd1;
    localparam logic [1:0] CFG_SEL_FLOW = 2'd2;

    localparam logic [31:0] INTERVAL_RST = 32'd100000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_START,
        ST_CNT_WAIT,
        ST_CNT_CHK,
        ST_SMP_STEP,
        ST_MEAN_WAIT,
        ST_SMP_OUT,
        ST_APPLY,
        ST_SRCH_RD,
        ST_SRCH_CHK
    } t_state;

    typedef struct packed {
        logic evt_ready;
        logic clr_wr;
        logic cnt_start;
        logic cnt_zero;
        logic cnt_latch;
        logic smp_step;
        logic mean_start;
        logic mean_latch;
        logic out_load;
        logic apply;
        logic srch_rd;
        logic srch_next;
        logic hit_commit;
        logic miss_commit;
    } t_dp_cmd;

    typedef struct packed {
        logic evt_take;
        logic filtered;
        logic clr_end;
        logic t_gt_clk;
        logic div_done;
        logic emit_zero;
        logic out_pkt_zero;
        logic out_free;
        logic last;
        logic act_other;
        logic match;
        logic srch_end;
    } t_dp_sts;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic signed [47:0] lvl48(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) begin
            return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return s[47:0];
    endfunction

    function automatic logic signed [31:0] lvl32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return s[31:0];
    endfunction

endpackage

@@ sv/qim_if.sv @@
// ----------------------------------------------------------------------------
// qim_if
// event, sample and configuration channels of the queue interval monitor
// ----------------------------------------------------------------------------
interface qim_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] event_time;
    logic [15:0] pkt_bytes;
    logic [30:0] packet_id;
    logic [19:0] flow_id;
    modport source (output valid, action, event_time, pkt_bytes, packet_id, flow_id,
                    input ready);
    modport sink (input valid, action, event_time, pkt_bytes, packet_id, flow_id,
                  output ready);
endinterface

interface qim_smp_if;
    logic               valid;
    logic               ready;
    logic [31:0]        sample_time;
    logic [31:0]        bits_in;
    logic [31:0]        pkts_in;
    logic [31:0]        bits_out;
    logic [31:0]        pkts_out;
    logic signed [47:0] backlog_bits;
    logic signed [31:0] backlog_pkts;
    logic [31:0]        bits_dropped;
    logic [31:0]        pkts_dropped;
    logic [31:0]        mean_delay;
    logic               gap_skipped;
    logic               last_sample;
    modport source (output valid, sample_time, bits_in, pkts_in, bits_out, pkts_out,
                    backlog_bits, backlog_pkts, bits_dropped, pkts_dropped,
                    mean_delay, gap_skipped, last_sample, input ready);
    modport sink (input valid, sample_time, bits_in, pkts_in, bits_out, pkts_out,
                  backlog_bits, backlog_pkts, bits_dropped, pkts_dropped,
                  mean_delay, gap_skipped, last_sample, output ready);
endinterface

interface qim_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/qim_ram.sv @@
// ----------------------------------------------------------------------------
// qim_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module qim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/qim_div.sv @@
// ----------------------------------------------------------------------------
// qim_div
// restoring divider, 48 bit dividend by 32 bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module qim_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [47:0] o_quo,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] sh;
    logic [33:0] diff;

    assign sh   = {r_rem, r_quo[47]};
    assign diff = {1'b0, sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[46:0], ~diff[33]};
            r_rem <= diff[33] ? sh[31:0] : diff[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ sv/qim_dp.sv @@
// ----------------------------------------------------------------------------
// qim_dp
// datapath: config, interval counters, queue levels, pending table, sample reg
// ----------------------------------------------------------------------------
module qim_dp
    import qim_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_SAMPLES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    qim_evt_if.sink   i_evt,
    qim_smp_if.source o_smp,
    qim_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = $clog2(MAX_SAMPLES + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // configuration
    logic [31:0] r_ivl;
    logic        r_filt_on;
    logic [19:0] r_sel_flow;
    logic [31:0] ivl_eff;

    // current item
    logic [1:0]  r_act;
    logic [31:0] r_t;
    logic [18:0] r_bits;
    logic [30:0] r_pid;

    // interval state
    logic [31:0]        r_clock;
    logic [31:0]        r_in_bits, r_in_pkts, r_out_bits, r_out_pkts;
    logic [31:0]        r_drop_bits, r_drop_pkts;
    logic signed [47:0] r_qbits;
    logic signed [31:0] r_qpkts;
    logic [47:0]        r_dsum;
    logic [AW-1:0]      r_ptr;

    // sampling
    logic [31:0]   r_rem;
    logic          r_gap;
    logic [KW-1:0] r_emit;
    logic [KW-1:0] r_k;
    logic [31:0]   r_mean;

    // table walk
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_n;
    logic [AW-1:0] r_clr;

    // sample register
    logic               r_o_valid;
    logic [31:0]        r_o_time, r_o_bits_in, r_o_pkts_in, r_o_bits_out, r_o_pkts_out;
    logic signed [47:0] r_o_qbits;
    logic signed [31:0] r_o_qpkts;
    logic [31:0]        r_o_drop_bits, r_o_drop_pkts, r_o_mean;
    logic               r_o_gap, r_o_last;

    // divider
    logic        div_start;
    logic [47:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [47:0] div_quo;
    logic [31:0] div_rem;

    // table ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [63:0]   ram_rdata;
    logic          ent_busy;
    logic [31:0]   ent_time;
    logic [30:0]   ent_id;

    logic               last;
    logic               out_free;
    logic               q_gap;
    logic [31:0]        dl;
    logic [48:0]        dsum_add;
    logic signed [47:0] bits_pos, bits_neg;

    assign ivl_eff  = (r_ivl == '0) ? 32'd1 : r_ivl;
    assign last     = ((r_k + KW'(1)) == r_emit);
    assign out_free = !r_o_valid || o_smp.ready;
    assign q_gap    = (div_quo > 48'(MAX_SAMPLES));

    assign ent_busy = ram_rdata[63];
    assign ent_time = ram_rdata[62:31];
    assign ent_id   = ram_rdata[30:0];

    assign bits_pos = 48'(r_bits);
    assign bits_neg = -48'(r_bits);
    assign dl       = (r_t > ent_time) ? (r_t - ent_time) : 32'd0;
    assign dsum_add = {1'b0, r_dsum} + 49'(dl);

    assign i_cfg.ready = 1'b1;
    assign i_evt.ready = i_cmd.evt_ready;

    // status
    always_comb begin
        o_sts              = '0;
        o_sts.evt_take     = i_evt.valid && i_cmd.evt_ready;
        o_sts.filtered     = r_filt_on && (i_evt.flow_id != r_sel_flow);
        o_sts.clr_end      = (r_clr == LAST_IDX);
        o_sts.t_gt_clk     = (r_t > r_clock);
        o_sts.div_done     = div_done;
        o_sts.emit_zero    = (r_emit == '0);
        o_sts.out_pkt_zero = (r_out_pkts == '0);
        o_sts.out_free     = out_free;
        o_sts.last         = last;
        o_sts.act_other    = (r_act == ACT_OTHER);
        o_sts.srch_end     = (r_n == LAST_IDX);
        if (r_act == ACT_ENQ) begin
            o_sts.match = !ent_busy;
        end else begin
            o_sts.match = ent_busy && (ent_id == r_pid);
        end
    end

    // divider operands: interval count or mean delay
    assign div_start    = i_cmd.cnt_start || i_cmd.mean_start;
    assign div_dividend = i_cmd.cnt_start ? {16'd0, r_t - r_clock - 32'd1} : r_dsum;
    assign div_divisor  = i_cmd.cnt_start ? ivl_eff : r_out_pkts;

    qim_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // table write: clearing pass, or commit of a hit
    always_comb begin
        ram_we    = i_cmd.clr_wr || i_cmd.hit_commit;
        ram_waddr = i_cmd.clr_wr ? r_clr : r_idx;
        if (i_cmd.hit_commit && (r_act == ACT_ENQ)) begin
            ram_wdata = {1'b1, r_t, r_pid};
        end else begin
            ram_wdata = '0;
        end
    end

    qim_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.srch_rd),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // configuration and interval state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivl       <= INTERVAL_RST;
            r_filt_on   <= 1'b0;
            r_sel_flow  <= '0;
            r_clock     <= '0;
            r_in_bits   <= '0;
            r_in_pkts   <= '0;
            r_out_bits  <= '0;
            r_out_pkts  <= '0;
            r_drop_bits <= '0;
            r_drop_pkts <= '0;
            r_qbits     <= '0;
            r_qpkts     <= '0;
            r_dsum      <= '0;
            r_ptr       <= '0;
            r_clr       <= '0;
            r_emit      <= '0;
            r_k         <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_INTERVAL: r_ivl      <= i_cfg.data;
                    CFG_FILT_ON:  r_filt_on  <= i_cfg.data[0];
                    CFG_SEL_FLOW: r_sel_flow <= i_cfg.data[19:0];
                    default: ;
                endcase
            end

            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end

            if (i_cmd.cnt_zero) begin
                r_emit <= '0;
            end
            if (i_cmd.cnt_latch) begin
                r_emit <= q_gap ? KW'(MAX_SAMPLES) : div_quo[KW-1:0];
                r_k    <= '0;
            end

            if (i_cmd.smp_step) begin
                r_clock <= r_clock + ivl_eff;
            end

            r_o_valid <= i_cmd.out_load || (r_o_valid && !o_smp.ready);
            if (i_cmd.out_load) begin
                r_k         <= r_k + KW'(1);
                r_in_bits   <= '0;
                r_in_pkts   <= '0;
                r_out_bits  <= '0;
                r_out_pkts  <= '0;
                r_drop_bits <= '0;
                r_drop_pkts <= '0;
                r_dsum      <= '0;
                // skipped intervals: clock lands on the last boundary before t
                if (last && r_gap) begin
                    r_clock <= r_t - 32'd1 - r_rem;
                end
            end

            if (i_cmd.apply) begin
                case (r_act)
                    ACT_ENQ: begin
                        r_in_bits <= sat_add32(r_in_bits, 32'(r_bits));
                        r_in_pkts <= sat_add32(r_in_pkts, 32'd1);
                        r_qbits   <= lvl48(r_qbits, bits_pos);
                        r_qpkts   <= lvl32(r_qpkts, 32'sd1);
                    end
                    ACT_DEQ: begin
                        r_out_bits <= sat_add32(r_out_bits, 32'(r_bits));
                        r_out_pkts <= sat_add32(r_out_pkts, 32'd1);
                        r_qbits    <= lvl48(r_qbits, bits_neg);
                        r_qpkts    <= lvl32(r_qpkts, -32'sd1);
                    end
                    ACT_DROP: begin
                        r_drop_bits <= sat_add32(r_drop_bits, 32'(r_bits));
                        r_drop_pkts <= sat_add32(r_drop_pkts, 32'd1);
                    end
                    default: ;
                endcase
            end

            if (i_cmd.hit_commit) begin
                r_ptr <= r_idx;
                if (r_act == ACT_DEQ) begin
                    r_dsum <= dsum_add[48] ? '1 : dsum_add[47:0];
                end
                if (r_act == ACT_DROP) begin
                    r_qbits <= lvl48(r_qbits, bits_neg);
                    r_qpkts <= lvl32(r_qpkts, -32'sd1);
                end
            end
            // missed drop steps the search start back by one
            if (i_cmd.miss_commit && (r_act == ACT_DROP)) begin
                r_ptr <= (r_ptr == '0) ? LAST_IDX : r_ptr - AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_sts.evt_take) begin
            r_act  <= i_evt.action;
            r_t    <= i_evt.event_time;
            r_bits <= {i_evt.pkt_bytes, 3'b000};
            r_pid  <= i_evt.packet_id;
        end
        if (i_cmd.cnt_zero) begin
            r_gap <= 1'b0;
        end
        if (i_cmd.cnt_latch) begin
            r_gap <= q_gap;
            r_rem <= div_rem;
        end
        if (i_cmd.smp_step) begin
            r_mean <= '0;
        end
        if (i_cmd.mean_latch) begin
            r_mean <= (div_quo[47:32] != '0) ? '1 : div_quo[31:0];
        end
        if (i_cmd.apply) begin
            r_idx <= r_ptr;
            r_n   <= '0;
        end
        if (i_cmd.srch_next) begin
            r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
            r_n   <= r_n + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_o_time      <= r_clock;
            r_o_bits_in   <= r_in_bits;
            r_o_pkts_in   <= r_in_pkts;
            r_o_bits_out  <= r_out_bits;
            r_o_pkts_out  <= r_out_pkts;
            r_o_qbits     <= r_qbits;
            r_o_qpkts     <= r_qpkts;
            r_o_drop_bits <= r_drop_bits;
            r_o_drop_pkts <= r_drop_pkts;
            r_o_mean      <= r_mean;
            r_o_gap       <= r_gap;
            r_o_last      <= last;
        end
    end

    assign o_smp.valid        = r_o_valid;
    assign o_smp.sample_time  = r_o_time;
    assign o_smp.bits_in      = r_o_bits_in;
    assign o_smp.pkts_in      = r_o_pkts_in;
    assign o_smp.bits_out     = r_o_bits_out;
    assign o_smp.pkts_out     = r_o_pkts_out;
    assign o_smp.backlog_bits = r_o_qbits;
    assign o_smp.backlog_pkts = r_o_qpkts;
    assign o_smp.bits_dropped = r_o_drop_bits;
    assign o_smp.pkts_dropped = r_o_drop_pkts;
    assign o_smp.mean_delay   = r_o_mean;
    assign o_smp.gap_skipped  = r_o_gap;
    assign o_smp.last_sample  = r_o_last;
endmodule

@@ sv/qim_ctrl.sv @@
// ----------------------------------------------------------------------------
// qim_ctrl
// controller: table clear, interval count, sample emission, table search
// ----------------------------------------------------------------------------
module qim_ctrl
    import qim_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.evt_ready = 1'b1;
                // filtered items are taken and forgotten
                if (i_sts.evt_take && !i_sts.filtered) begin
                    n_state = ST_CNT_START;
                end
            end
            ST_CNT_START: begin
                if (i_sts.t_gt_clk) begin
                    o_cmd.cnt_start = 1'b1;
                    n_state = ST_CNT_WAIT;
                end else begin
                    o_cmd.cnt_zero = 1'b1;
                    n_state = ST_APPLY;
                end
            end
            ST_CNT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cnt_latch = 1'b1;
                    n_state = ST_CNT_CHK;
                end
            end
            ST_CNT_CHK: begin
                n_state = i_sts.emit_zero ? ST_APPLY : ST_SMP_STEP;
            end
            ST_SMP_STEP: begin
                o_cmd.smp_step = 1'b1;
                if (i_sts.out_pkt_zero) begin
                    n_state = ST_SMP_OUT;
                end else begin
                    o_cmd.mean_start = 1'b1;
                    n_state = ST_MEAN_WAIT;
                end
            end
            ST_MEAN_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.mean_latch = 1'b1;
                    n_state = ST_SMP_OUT;
                end
            end
            ST_SMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = i_sts.last ? ST_APPLY : ST_SMP_STEP;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = i_sts.act_other ? ST_IDLE : ST_SRCH_RD;
            end
            ST_SRCH_RD: begin
                o_cmd.srch_rd = 1'b1;
                n_state = ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
                if (i_sts.match) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_sts.srch_end) begin
                    o_cmd.miss_commit = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.srch_next = 1'b1;
                    n_state = ST_SRCH_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

@@ sv/queue_interval_monitor_top.sv @@
// ----------------------------------------------------------------------------
// queue_interval_monitor_top
// per-interval queue statistics from a stream of queue events
// ----------------------------------------------------------------------------
// one item at a time: a filtered item is only taken; others are counted against the interval
// clock, with the 48-step shared divider when the event time is past it, then emit their
// samples (a mean delay division for each with packets out), subject to output stalls,
// then, unless the action is other, search the table (1 to TABLE_DEPTH entries, one ram read per entry)
// after reset all TABLE_DEPTH table busy bits are cleared, no item taken meanwhile
module queue_interval_monitor_top
    import qim_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_SAMPLES = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    qim_evt_if.sink   i_evt,
    qim_smp_if.source o_smp,
    qim_cfg_if.sink   i_cfg
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    qim_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    qim_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_evt   (i_evt),
        .o_smp   (o_smp),
        .i_cfg   (i_cfg)
    );
endmodule

@@ sv/qim_chk.sv @@
// ----------------------------------------------------------------------------
// qim_chk
// port level checks of the queue interval monitor
// ----------------------------------------------------------------------------
module qim_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_evt_ready,
    input logic        i_smp_valid,
    input logic        i_smp_ready,
    input logic [31:0] i_smp_time,
    input logic [31:0] i_smp_pkts_out,
    input logic [31:0] i_smp_mean,
    input logic        i_smp_last
);
    // a stalled sample holds
    a_smp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_smp_valid && !i_smp_ready |=> i_smp_valid && $stable(i_smp_time))
        else $error("sample dropped or changed while stalled");

    // no new item while an event still has samples to give
    a_busy_mid_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_smp_valid && !i_smp_last |-> !i_evt_ready)
        else $error("item taken in the middle of a sample burst");

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_smp_valid && (i_smp_pkts_out == 32'd0) |-> (i_smp_mean == 32'd0))
        else $error("mean delay without dequeued packets");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_smp_valid && !i_evt_ready)
        else $error("activity right after reset");
endmodule

bind queue_interval_monitor_top qim_chk u_qim_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_evt_ready    (i_evt.ready),
    .i_smp_valid    (o_smp.valid),
    .i_smp_ready    (o_smp.ready),
    .i_smp_time     (o_smp.sample_time),
    .i_smp_pkts_out (o_smp.pkts_out),
    .i_smp_mean     (o_smp.mean_delay),
    .i_smp_last     (o_smp.last_sample)
);
